>>> sv/gcel_pkg.sv
// gcel_pkg: shared types and constants for the grid cell labeling block
// command and result transaction structs, opcodes, label width
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package gcel_pkg;

  localparam int LABEL_W = 9;
  localparam int COORD_W = 4;

  localparam logic [LABEL_W-1:0] LABEL_TOP   = 9'd511;
  localparam logic [LABEL_W-1:0] LABEL_NONE  = 9'd0;
  localparam logic [LABEL_W-1:0] LABEL_FIRST = 9'd1;

  localparam logic OP_JOIN = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef struct packed {
    logic               operation;
    logic [COORD_W-1:0] row_a;
    logic [COORD_W-1:0] col_a;
    logic [COORD_W-1:0] row_b;
    logic [COORD_W-1:0] col_b;
  } cmd_t;

  typedef struct packed {
    logic [LABEL_W-1:0] label;
    logic [LABEL_W-1:0] retired_label;
    logic               fresh_label;
  } result_t;

endpackage

`default_nettype wire

>>> sv/grid_cell_equivalence_labeling.sv
// grid_cell_equivalence_labeling: top level, sequencer plus label store
// depends on gcel_pkg, gcel_ctrl, gcel_mem
//
// channel   direction  handshake                     payload
// command   in         start & !busy                 cmd    (gcel_pkg::cmd_t)
// result    out        done, one cycle, no stall     result (gcel_pkg::result_t)
//
// after reset the store is cleared one entry a cycle, with busy high throughout
// merging join: one store entry per cycle through the
// store's read and write ports
// busy stays high from acceptance until the result strobe; the receiver cannot stall
`timescale 1ns / 1ps
`default_nettype none

module grid_cell_equivalence_labeling #(
  parameter int SIDE = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire gcel_pkg::cmd_t    cmd,
  output logic                   busy,
  output logic                   done,
  output gcel_pkg::result_t      result
);

  localparam int CELLS = SIDE * SIDE;
  localparam int AW    = $clog2(CELLS);

  logic                         mem_we;
  logic [AW-1:0]                mem_waddr;
  logic [gcel_pkg::LABEL_W-1:0] mem_wdata;
  logic [AW-1:0]                mem_raddr;
  logic [gcel_pkg::LABEL_W-1:0] mem_rdata;

  gcel_ctrl #(
    .SIDE (SIDE)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .cmd       (cmd),
    .busy      (busy),
    .done      (done),
    .result    (result),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  gcel_mem #(
    .DEPTH (CELLS)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("not busy after accepted transaction");

  a_done_ends_work: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without work in progress");

  a_fresh_not_retired: assert property (@(posedge clk) disable iff (rst)
    (done && result.fresh_label) |->
      (result.retired_label == gcel_pkg::LABEL_NONE && result.label != gcel_pkg::LABEL_NONE))
    else $error("fresh label result inconsistent");

  a_retire_keeps_lower: assert property (@(posedge clk) disable iff (rst)
    (done && result.retired_label != gcel_pkg::LABEL_NONE) |->
      (result.label < result.retired_label && result.label != gcel_pkg::LABEL_NONE))
    else $error("merge kept the larger label");

endmodule

`default_nettype wire

>>> sv/gcel_mem.sv
// gcel_mem: label store, one write port and one registered read port
// depends on gcel_pkg for the label width
`timescale 1ns / 1ps
`default_nettype none

module gcel_mem #(
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic                         clk,
  input  wire logic                         we,
  input  wire logic [AW-1:0]                waddr,
  input  wire logic [gcel_pkg::LABEL_W-1:0] wdata,
  input  wire logic [AW-1:0]                raddr,
  output logic      [gcel_pkg::LABEL_W-1:0] rdata
);

  logic [gcel_pkg::LABEL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> sv/gcel_ctrl.sv
// gcel_ctrl: sequencer for clear, lookup, join and relabel sweep
// one shared label comparator serves both the join decision and the sweep match
// depends on gcel_pkg; drives the gcel_mem ports
`timescale 1ns / 1ps
`default_nettype none

module gcel_ctrl #(
  parameter int SIDE = 16,
  localparam int CELLS = SIDE * SIDE,
  localparam int AW = $clog2(CELLS)
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire gcel_pkg::cmd_t               cmd,
  output logic                              busy,
  output logic                              done,
  output gcel_pkg::result_t                 result,
  output logic                              mem_we,
  output logic      [AW-1:0]                mem_waddr,
  output logic      [gcel_pkg::LABEL_W-1:0] mem_wdata,
  output logic      [AW-1:0]                mem_raddr,
  input  wire logic [gcel_pkg::LABEL_W-1:0] mem_rdata
);

  localparam int CNT_W = AW + 1;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_RDA   = 7'b0000100,
    S_RDB   = 7'b0001000,
    S_DEC   = 7'b0010000,
    S_WR    = 7'b0100000,
    S_SWEEP = 7'b1000000
  } state_t;

  state_t                       state;
  logic [CNT_W-1:0]             cnt;
  logic [gcel_pkg::LABEL_W-1:0] next_label;
  logic                         pend;
  logic                         wr_both;
  logic                         done_next;

  logic                         op_q;
  logic [AW-1:0]                idx_a;
  logic [AW-1:0]                idx_b;
  logic                         ok_a;
  logic                         ok_b;
  logic [gcel_pkg::LABEL_W-1:0] la;
  logic [gcel_pkg::LABEL_W-1:0] lo;
  logic [gcel_pkg::LABEL_W-1:0] hi;
  logic [AW-1:0]                wr_addr;
  logic [gcel_pkg::LABEL_W-1:0] wr_data;
  logic [AW-1:0]                pend_idx;

  logic [gcel_pkg::LABEL_W-1:0] cmp_ref;
  logic                         eq_hit;
  logic                         in_a;
  logic                         in_b;
  logic [AW-1:0]                cidx_a;
  logic [AW-1:0]                cidx_b;

  // shared comparator: sweep matches against the retiring label, join against la
  assign cmp_ref = (state == S_SWEEP) ? hi : la;
  assign eq_hit  = (mem_rdata == cmp_ref);

  assign in_a   = (int'(cmd.row_a) < SIDE) && (int'(cmd.col_a) < SIDE);
  assign in_b   = (int'(cmd.row_b) < SIDE) && (int'(cmd.col_b) < SIDE);
  assign cidx_a = AW'(int'(cmd.row_a) * SIDE + int'(cmd.col_a));
  assign cidx_b = AW'(int'(cmd.row_b) * SIDE + int'(cmd.col_b));

  assign busy = (state != S_IDLE);

  // result strobe follows the last busy cycle of each transaction
  always_comb begin
    done_next = 1'b0;
    case (state)
      S_RDB: done_next = (op_q == gcel_pkg::OP_READ) || !(ok_a && ok_b);
      S_DEC: done_next = (la != gcel_pkg::LABEL_NONE) &&
                         (mem_rdata != gcel_pkg::LABEL_NONE) && eq_hit;
      S_WR: done_next = !wr_both;
      S_SWEEP: done_next = (cnt == CNT_W'(CELLS));
      default: done_next = 1'b0;
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = wr_addr;
    mem_wdata = wr_data;
    mem_raddr = idx_a;
    case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = cnt[AW-1:0];
        mem_wdata = gcel_pkg::LABEL_NONE;
      end
      S_RDA: mem_raddr = idx_a;
      S_RDB: mem_raddr = idx_b;
      S_WR: mem_we = 1'b1;
      S_SWEEP: begin
        // read entry cnt while rewriting the entry read in the cycle before
        mem_raddr = cnt[AW-1:0];
        mem_we    = pend && eq_hit;
        mem_waddr = pend_idx;
        mem_wdata = lo;
      end
      default: mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      cnt        <= '0;
      next_label <= gcel_pkg::LABEL_FIRST;
      done       <= 1'b0;
      pend       <= 1'b0;
      wr_both    <= 1'b0;
    end else begin
      done <= done_next;
      case (state)
        S_CLEAR: begin
          if (cnt == CNT_W'(CELLS - 1)) begin
            cnt   <= '0;
            state <= S_IDLE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_IDLE: begin
          if (start) begin
            op_q  <= cmd.operation;
            idx_a <= cidx_a;
            idx_b <= cidx_b;
            ok_a  <= in_a;
            ok_b  <= in_b;
            state <= S_RDA;
          end
        end
        S_RDA: state <= S_RDB;
        S_RDB: begin
          la <= mem_rdata;
          if (op_q == gcel_pkg::OP_READ) begin
            result.label         <= ok_a ? mem_rdata : gcel_pkg::LABEL_NONE;
            result.retired_label <= gcel_pkg::LABEL_NONE;
            result.fresh_label   <= 1'b0;
            state                <= S_IDLE;
          end else if (!(ok_a && ok_b)) begin
            result.label         <= gcel_pkg::LABEL_NONE;
            result.retired_label <= gcel_pkg::LABEL_NONE;
            result.fresh_label   <= 1'b0;
            state                <= S_IDLE;
          end else begin
            state <= S_DEC;
          end
        end
        S_DEC: begin
          // mem_rdata holds the label of cell b here
          if (la == gcel_pkg::LABEL_NONE && mem_rdata == gcel_pkg::LABEL_NONE) begin
            wr_addr              <= idx_a;
            wr_data              <= next_label;
            wr_both              <= 1'b1;
            result.label         <= next_label;
            result.retired_label <= gcel_pkg::LABEL_NONE;
            result.fresh_label   <= 1'b1;
            if (next_label != gcel_pkg::LABEL_TOP) begin
              next_label <= next_label + 1'b1;
            end
            state <= S_WR;
          end else if (la == gcel_pkg::LABEL_NONE) begin
            wr_addr              <= idx_a;
            wr_data              <= mem_rdata;
            result.label         <= mem_rdata;
            result.retired_label <= gcel_pkg::LABEL_NONE;
            result.fresh_label   <= 1'b0;
            state                <= S_WR;
          end else if (mem_rdata == gcel_pkg::LABEL_NONE) begin
            wr_addr              <= idx_b;
            wr_data              <= la;
            result.label         <= la;
            result.retired_label <= gcel_pkg::LABEL_NONE;
            result.fresh_label   <= 1'b0;
            state                <= S_WR;
          end else if (eq_hit) begin
            result.label         <= la;
            result.retired_label <= gcel_pkg::LABEL_NONE;
            result.fresh_label   <= 1'b0;
            state                <= S_IDLE;
          end else begin
            if (la < mem_rdata) begin
              lo <= la;
              hi <= mem_rdata;
              result.label         <= la;
              result.retired_label <= mem_rdata;
            end else begin
              lo <= mem_rdata;
              hi <= la;
              result.label         <= mem_rdata;
              result.retired_label <= la;
            end
            result.fresh_label <= 1'b0;
            cnt   <= '0;
            pend  <= 1'b0;
            state <= S_SWEEP;
          end
        end
        S_WR: begin
          if (wr_both) begin
            wr_addr <= idx_b;
            wr_both <= 1'b0;
          end else begin
            state <= S_IDLE;
          end
        end
        S_SWEEP: begin
          if (cnt != CNT_W'(CELLS)) begin
            cnt      <= cnt + 1'b1;
            pend     <= 1'b1;
            pend_idx <= cnt[AW-1:0];
          end else begin
            pend  <= 1'b0;
            cnt   <= '0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> test/tb.sv
// tb: self-checking bench for grid_cell_equivalence_labeling at SIDE = 16
// directed joins and reads, then random neighbor, far and same-cell joins with reads,
// all checked against a label-grid predictor; depends on gcel_pkg and the block
`timescale 1ns / 1ps

module tb;

  localparam int SIDE = 16;
  localparam int CELLS = SIDE * SIDE;
  localparam int RANDOM_ITEMS = 850;
  localparam int PHASE_LEN = 71;
  localparam int SETTLE_CYCLES = CELLS + 16;

  typedef struct {
    gcel_pkg::cmd_t cmd;
    int unsigned    idle_pct;
    bit             drain_first;
  } stim_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  gcel_pkg::cmd_t    cmd = '0;
  logic              busy;
  logic              done;
  gcel_pkg::result_t result;

  stim_t             cmd_backlog[$];
  gcel_pkg::result_t labels_due[$];
  int                cmds_taken = 0;
  int                results_seen = 0;
  int                mismatches = 0;

  // predictor state
  logic [gcel_pkg::LABEL_W-1:0] cell_label [0:CELLS-1] = '{default: gcel_pkg::LABEL_NONE};
  logic [gcel_pkg::LABEL_W-1:0] next_fresh = gcel_pkg::LABEL_FIRST;

  grid_cell_equivalence_labeling #(.SIDE(SIDE)) dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic gcel_pkg::result_t apply_to_grid(gcel_pkg::cmd_t c);
    gcel_pkg::result_t            r;
    int                           ia;
    int                           ib;
    bit                           in_a;
    bit                           in_b;
    logic [gcel_pkg::LABEL_W-1:0] la;
    logic [gcel_pkg::LABEL_W-1:0] lb;
    logic [gcel_pkg::LABEL_W-1:0] lo;
    logic [gcel_pkg::LABEL_W-1:0] hi;
    r = '0;
    in_a = (c.row_a < SIDE) && (c.col_a < SIDE);
    in_b = (c.row_b < SIDE) && (c.col_b < SIDE);
    ia = c.row_a * SIDE + c.col_a;
    ib = c.row_b * SIDE + c.col_b;
    if (c.operation == gcel_pkg::OP_READ) begin
      if (in_a) r.label = cell_label[ia];
      return r;
    end
    if (!in_a || !in_b) return r;
    la = cell_label[ia];
    lb = cell_label[ib];
    if (la == gcel_pkg::LABEL_NONE && lb == gcel_pkg::LABEL_NONE) begin
      r.label = next_fresh;
      r.fresh_label = 1'b1;
      cell_label[ia] = next_fresh;
      cell_label[ib] = next_fresh;
      if (next_fresh != gcel_pkg::LABEL_TOP) next_fresh = next_fresh + 1'b1;
    end else if (la == gcel_pkg::LABEL_NONE) begin
      r.label = lb;
      cell_label[ia] = lb;
    end else if (lb == gcel_pkg::LABEL_NONE) begin
      r.label = la;
      cell_label[ib] = la;
    end else if (la == lb) begin
      r.label = la;
    end else begin
      lo = (la < lb) ? la : lb;
      hi = (la < lb) ? lb : la;
      foreach (cell_label[k]) begin
        if (cell_label[k] == hi) cell_label[k] = lo;
      end
      r.label = lo;
      r.retired_label = hi;
    end
    return r;
  endfunction

  function automatic gcel_pkg::cmd_t mk_cmd(logic op, int ra, int ca, int rb, int cb);
    gcel_pkg::cmd_t c;
    c.operation = op;
    c.row_a = ra[gcel_pkg::COORD_W-1:0];
    c.col_a = ca[gcel_pkg::COORD_W-1:0];
    c.row_b = rb[gcel_pkg::COORD_W-1:0];
    c.col_b = cb[gcel_pkg::COORD_W-1:0];
    return c;
  endfunction

  task automatic queue_cmd(gcel_pkg::cmd_t c, int unsigned idle_pct, bit drain_first);
    stim_t s;
    s.cmd = c;
    s.idle_pct = idle_pct;
    s.drain_first = drain_first;
    cmd_backlog.insert(cmd_backlog.size(), s);
  endtask

  // driver: holds start until the transaction is taken, idles at random between transactions
  always @(posedge clk) begin : drive_cmd
    gcel_pkg::result_t due;
    logic              raise;
    int                taken_now;
    if (rst) begin
      start <= 1'b0;
    end else begin
      raise = start;
      taken_now = cmds_taken;
      if (start && !busy) begin
        due = apply_to_grid(cmd);
        labels_due.insert(labels_due.size(), due);
        taken_now = cmds_taken + 1;
        cmds_taken <= taken_now;
        raise = 1'b0;
      end
      if (!raise && cmd_backlog.size() > 0) begin
        if (cmd_backlog[0].drain_first && taken_now == results_seen)
          cmd_backlog[0].drain_first = 1'b0;
        if (!cmd_backlog[0].drain_first &&
            $urandom_range(99) >= cmd_backlog[0].idle_pct) begin
          cmd <= cmd_backlog[0].cmd;
          cmd_backlog.pop_front();
          raise = 1'b1;
        end
      end
      start <= raise;
    end
  end

  always @(posedge clk) begin : watch_results
    gcel_pkg::result_t want;
    if (!rst && done) begin
      results_seen <= results_seen + 1;
      if (labels_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: label %0d retired %0d fresh %0d",
                   result.label, result.retired_label, result.fresh_label);
      end else begin
        want = labels_due.pop_front();
        if (result.label !== want.label || result.retired_label !== want.retired_label ||
            result.fresh_label !== want.fresh_label) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected label %0d retired %0d fresh %0d, %s",
                     want.label, want.retired_label, want.fresh_label,
                     $sformatf("got label %0d retired %0d fresh %0d",
                               result.label, result.retired_label, result.fresh_label));
        end
      end
    end
  end

  initial begin : stimulus
    int ra;
    int ca;
    int rb;
    int cb;
    int pick;
    int unsigned idle;
    int unsigned phase_idle [4];

    phase_idle = '{0, 78, 0, 34};

    // directed: empty reads, same cell, copies both ways, merges both ways
    queue_cmd(mk_cmd(gcel_pkg::OP_READ, 0, 0, 15, 15), 0, 0);
    queue_cmd(mk_cmd(gcel_pkg::OP_READ, 15, 15, 0, 0), 0, 0);
    queue_cmd(mk_cmd(gcel_pkg::OP_JOIN, 0, 0, 0, 0), 0, 0);
    queue_cmd(mk_cmd(gcel_pkg::OP_JOIN, 0, 0, 0, 0), 0, 0);
    queue_cmd(mk_cmd(gcel_pkg::OP_JOIN, 0, 0, 0, 1), 0, 0);
    queue_cmd(mk_cmd(gcel_pkg::OP_JOIN, 1, 0, 0, 0), 0, 0);
    queue_cmd(mk_cmd(gcel_pkg::OP_JOIN, 15, 15, 15, 14), 0, 0);
    queue_cmd(mk_cmd(gcel_pkg::OP_JOIN, 0, 0, 15, 15), 0, 0);
    queue_cmd(mk_cmd(gcel_pkg::OP_READ, 15, 14, 0, 0), 0, 1);
    queue_cmd(mk_cmd(gcel_pkg::OP_JOIN, 8, 8, 8, 9), 0, 0);
    queue_cmd(mk_cmd(gcel_pkg::OP_JOIN, 8, 8, 0, 1), 0, 0);
    queue_cmd(mk_cmd(gcel_pkg::OP_READ, 8, 9, 0, 0), 0, 0);
    queue_cmd(mk_cmd(gcel_pkg::OP_JOIN, 0, 1, 15, 14), 0, 0);
    queue_cmd(mk_cmd(gcel_pkg::OP_JOIN, 10, 5, 5, 10), 0, 0);
    queue_cmd(mk_cmd(gcel_pkg::OP_JOIN, 5, 10, 10, 5), 0, 0);
    queue_cmd(mk_cmd(gcel_pkg::OP_JOIN, 0, 15, 15, 0), 0, 0);
    queue_cmd(mk_cmd(gcel_pkg::OP_JOIN, 15, 0, 10, 5), 0, 0);
    queue_cmd(mk_cmd(gcel_pkg::OP_READ, 5, 10, 15, 15), 0, 0);
    queue_cmd(mk_cmd(gcel_pkg::OP_READ, 0, 15, 10, 10), 0, 0);
    queue_cmd(mk_cmd(gcel_pkg::OP_READ, 7, 3, 0, 0), 0, 0);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      idle = phase_idle[(i / PHASE_LEN) % 4];
      ra = $urandom_range(SIDE - 1);
      ca = $urandom_range(SIDE - 1);
      rb = $urandom_range(SIDE - 1);
      cb = $urandom_range(SIDE - 1);
      pick = $urandom_range(99);
      if (pick < 45) begin
        queue_cmd(mk_cmd(gcel_pkg::OP_READ, ra, ca, rb, cb), idle, i % PHASE_LEN == 0);
      end else begin
        if (pick < 52) begin
          rb = ra;
          cb = ca;
        end else if (pick < 80) begin
          // neighbor joins grow regions slowly, keeping several labels alive
          rb = ra;
          cb = ca;
          case ($urandom_range(3))
            0: rb = (ra + 1) % SIDE;
            1: rb = (ra + SIDE - 1) % SIDE;
            2: cb = (ca + 1) % SIDE;
            default: cb = (ca + SIDE - 1) % SIDE;
          endcase
        end
        queue_cmd(mk_cmd(gcel_pkg::OP_JOIN, ra, ca, rb, cb), idle, i % PHASE_LEN == 0);
      end
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (cmd_backlog.size() != 0 || start || cmds_taken != results_seen)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    mismatches += labels_due.size();
    if (mismatches == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

>>> sim.f
sv/gcel_pkg.sv
sv/gcel_mem.sv
sv/gcel_ctrl.sv
sv/grid_cell_equivalence_labeling.sv
test/tb.sv
